@@ rtl/core/wdc_pkg.sv @@
// ----------------------------------------------------------------------------
// wdc_pkg
// Shared widths, register indexes, payload types and the log2 fraction table
// for the waveform density colouriser.
// ----------------------------------------------------------------------------
package wdc_pkg;

   localparam int DENSITY_BITS   = 24;
   localparam int COORD_BITS     = 12;
   localparam int MAXD_BITS      = 24;
   localparam int SIZE_BITS      = 13;
   localparam int FRAC_BITS      = 16;
   localparam int IDX_BITS       = 8;
   localparam int ROM_DEPTH      = 1 << IDX_BITS;
   localparam int GRID_BITS      = 15;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 24;
   localparam int COLOUR_BITS    = 8;

   // Integer part of the log covers the wider of the two log operands.
   localparam int POS_MAX  = (DENSITY_BITS > MAXD_BITS) ? DENSITY_BITS : MAXD_BITS;
   localparam int POS_BITS = $clog2(POS_MAX + 1);
   localparam int LOG_BITS = POS_BITS + FRAC_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_DENSITY  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;

   localparam logic [COLOUR_BITS-1:0] GRID_LEVEL = 8'd40;
   localparam logic [COLOUR_BITS-1:0] FULL_LEVEL = 8'd255;
   localparam logic [COLOUR_BITS-1:0] RED_GAIN   = 8'd180;
   localparam logic [COLOUR_BITS-1:0] BLUE_GAIN  = 8'd100;

   typedef struct packed {
      logic [DENSITY_BITS-1:0] density;
      logic [COORD_BITS-1:0]   col;
      logic [COORD_BITS-1:0]   row;
   } req_type;

   typedef struct packed {
      logic [COLOUR_BITS-1:0] red;
      logic [COLOUR_BITS-1:0] green;
      logic [COLOUR_BITS-1:0] blue;
      logic [COLOUR_BITS-1:0] alpha;
   } rsp_type;

   // Control that travels alongside each pixel through the pipeline.
   typedef struct packed {
      logic vld;
      logic grid;
      logic nz;
   } tag_type;

   // Fraction of log2((256+i)/256), truncated to 16 bits, by repeated squaring
   // in Q1.30.
   function automatic logic [ROM_DEPTH*FRAC_BITS-1:0] build_frac_rom();
      logic [63:0]                      x;
      logic [FRAC_BITS-1:0]             f;
      logic [ROM_DEPTH*FRAC_BITS-1:0]   rom;
      rom = '0;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         x = 64'(ROM_DEPTH + i) << 22;
         f = '0;
         for (int k = 0; k < FRAC_BITS; k++) begin
            x = (x * x) >> 30;
            f = {f[FRAC_BITS-2:0], 1'b0};
            if (x >= 64'h0000_0000_8000_0000) begin
               f[0] = 1'b1;
               x    = x >> 1;
            end
         end
         rom[i*FRAC_BITS +: FRAC_BITS] = f;
      end
      return rom;
   endfunction

   localparam logic [ROM_DEPTH*FRAC_BITS-1:0] FRAC_ROM = build_frac_rom();

   function automatic logic [FRAC_BITS-1:0] frac_of(input logic [IDX_BITS-1:0] idx);
      return FRAC_ROM[{idx, 4'd0} +: FRAC_BITS];
   endfunction

endpackage

@@ rtl/core/waveform_density_colorizer.sv @@
// ----------------------------------------------------------------------------
// waveform_density_colorizer
// Throughput: one pixel per clock while no register write is pending; the
// 16-stage restoring divider that forms the normalised density retires one
// quotient bit per stage. Reset (synchronous, active high) empties the
// pipeline and loads max_density 1 and a 256 x 256 display; the receiver
// cannot stall, so rsp_strobe is never held off.
// ----------------------------------------------------------------------------
module waveform_density_colorizer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  wdc_pkg::req_type                     req_data,
   output logic                                 rsp_strobe,
   output wdc_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wdc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [wdc_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int DB   = wdc_pkg::DENSITY_BITS;
   localparam int MB   = wdc_pkg::MAXD_BITS;
   localparam int SB   = wdc_pkg::SIZE_BITS;
   localparam int GB   = wdc_pkg::GRID_BITS;
   localparam int LB   = wdc_pkg::LOG_BITS;
   localparam int FB   = wdc_pkg::FRAC_BITS;
   localparam int CW   = wdc_pkg::COLOUR_BITS;

   // Pipeline stage positions, counted from the input register.
   localparam int ST_LOG  = 3;               // log2 results valid
   localparam int ST_DIV0 = ST_LOG + 1;      // divider set-up
   localparam int ST_QUOT = ST_DIV0 + FB;    // quotient complete
   localparam int ST_SQR  = ST_QUOT + 1;     // n squared, green ramp
   localparam int ST_GAIN = ST_SQR + 1;      // red and blue ramps
   localparam int NST     = ST_GAIN + 2;     // output register is the last

   localparam logic [FB:0] ONE_Q16 = (FB + 1)'(1) << FB;

   // ------------------------------------------------------------------------
   // Configuration registers. A write is only taken once every pixel in flight
   // has left, so the whole pipeline always sees one consistent setting. The
   // start side is held off during a pending write so that the two never
   // share an edge.
   // ------------------------------------------------------------------------
   logic [MB-1:0] max_ff;
   logic [SB-1:0] width_ff;
   logic [SB-1:0] height_ff;
   logic          inflight;
   logic          accept;

   wdc_pkg::tag_type tag_ff [NST];

   always_comb begin
      inflight = 1'b0;
      for (int i = 0; i < NST; i++) begin
         inflight = inflight | tag_ff[i].vld;
      end
   end

   assign csr_ready = ~inflight;
   assign busy      = csr_valid;
   assign accept    = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff    <= MB'(1);
         width_ff  <= SB'(256);
         height_ff <= SB'(256);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            wdc_pkg::REG_MAX_DENSITY:  max_ff    <= csr_wdata[MB-1:0];
            wdc_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[SB-1:0];
            wdc_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata[SB-1:0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Input stage: grid test against the quarter, half and three-quarter
   // positions (truncating division by four is a shift), and density + 1
   // ready for the logarithm.
   // ------------------------------------------------------------------------
   function automatic logic on_line(input logic [GB-1:0] pos, input logic [SB-1:0] size);
      logic [GB-1:0] s;
      logic [GB-1:0] a;
      logic [GB-1:0] b;
      logic [GB-1:0] c;
      s = GB'(size);
      a = s >> 2;
      b = s >> 1;
      c = (s + (s << 1)) >> 2;
      return (size != '0) && ((pos == a) || (pos == b) || (pos == c));
   endfunction

   logic          grid_in;
   logic [DB:0]   dp1_in;
   logic [DB:0]   dp1_ff;
   logic [MB:0]   mp1;
   logic [LB-1:0] ld;
   logic [LB-1:0] lm;

   assign grid_in = on_line(GB'(req_data.row), height_ff) ||
                    on_line(GB'(req_data.col), width_ff);
   assign dp1_in  = {1'b0, req_data.density} + (DB + 1)'(1);

   // A zero reference is treated as one.
   assign mp1 = (max_ff == '0) ? (MB + 1)'(2) : ({1'b0, max_ff} + (MB + 1)'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NST; i++) begin
            tag_ff[i] <= '0;
         end
      end else begin
         tag_ff[0] <= '{vld: accept, grid: grid_in, nz: (req_data.density != '0)};
         for (int i = 1; i < NST; i++) begin
            tag_ff[i] <= tag_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      dp1_ff <= dp1_in;
   end

   // Both logarithms run through identical three-stage units. The reference
   // only changes while the pipeline is empty, so its log arrives in step
   // with the first pixel that needs it.
   wdc_log2 #(
      .VAL_BITS (DB + 1),
      .LOG_BITS (LB)
   ) u_log_density (
      .clock  (clock),
      .value  (dp1_ff),
      .result (ld)
   );

   wdc_log2 #(
      .VAL_BITS (MB + 1),
      .LOG_BITS (LB)
   ) u_log_max (
      .clock  (clock),
      .value  (mp1),
      .result (lm)
   );

   // ------------------------------------------------------------------------
   // Normalisation n = ld / lm in Q0.16. When ld is not below lm the result
   // saturates at 1.0; otherwise ld < lm and a restoring divider produces the
   // sixteen fraction bits, one per stage, with the remainder kept below lm.
   // ------------------------------------------------------------------------
   logic [LB-1:0] rem_ff [FB+1];
   logic [FB-1:0] quo_ff [FB+1];
   logic          sat_ff [FB+1];
   logic [LB-1:0] rem_in [FB+1];
   logic [FB-1:0] quo_in [FB+1];
   logic          sat_in;

   assign sat_in    = (ld >= lm);
   assign rem_in[0] = sat_in ? '0 : ld;
   assign quo_in[0] = '0;

   genvar k;
   generate
      for (k = 1; k <= FB; k++) begin : g_div
         logic [LB:0] two_rem;
         logic        take;
         assign two_rem   = {rem_ff[k-1], 1'b0};
         assign take      = (two_rem >= {1'b0, lm});
         assign rem_in[k] = take ? LB'(two_rem - {1'b0, lm}) : two_rem[LB-1:0];
         assign quo_in[k] = {quo_ff[k-1][FB-2:0], take};
      end
   endgenerate

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in[0];
      quo_ff[0] <= quo_in[0];
      sat_ff[0] <= sat_in;
      for (int i = 1; i <= FB; i++) begin
         rem_ff[i] <= rem_in[i];
         quo_ff[i] <= quo_in[i];
         sat_ff[i] <= sat_ff[i-1];
      end
   end

   // ------------------------------------------------------------------------
   // Colour ramps. Green is n * 255 (as a shift and subtract), red and blue
   // scale n squared, which needs its own register before the gains.
   // ------------------------------------------------------------------------
   logic [FB:0]        n_q16;
   logic [2*FB:0]      nn_ff;
   logic [FB+CW:0]     n255;
   logic [CW-1:0]      green_ff;
   logic [CW-1:0]      green2_ff;
   logic [2*FB+CW:0]   red_prod;
   logic [2*FB+CW:0]   blue_prod;
   logic [CW-1:0]      red_ff;
   logic [CW-1:0]      blue_ff;

   assign n_q16 = sat_ff[FB] ? ONE_Q16 : {1'b0, quo_ff[FB]};
   assign n255  = {n_q16, CW'(0)} - (FB + CW + 1)'(n_q16);

   assign red_prod  = (2*FB + CW + 1)'(nn_ff) * (2*FB + CW + 1)'(wdc_pkg::RED_GAIN);
   assign blue_prod = (2*FB + CW + 1)'(nn_ff) * (2*FB + CW + 1)'(wdc_pkg::BLUE_GAIN);

   always_ff @(posedge clock) begin
      nn_ff     <= (2*FB + 1)'(n_q16) * (2*FB + 1)'(n_q16);
      green_ff  <= n255[FB+CW-1:FB];
      green2_ff <= green_ff;
      red_ff    <= red_prod[2*FB+CW-1:2*FB];
      blue_ff   <= blue_prod[2*FB+CW-1:2*FB];
   end

   // ------------------------------------------------------------------------
   // Output stage: grid base colour, saturating add of the ramps, alpha.
   // ------------------------------------------------------------------------
   function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a, input logic [CW-1:0] b);
      logic [CW:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CW] ? wdc_pkg::FULL_LEVEL : s[CW-1:0];
   endfunction

   wdc_pkg::tag_type  gain_tag;
   logic [CW-1:0]     base;
   wdc_pkg::rsp_type  rsp_in;
   wdc_pkg::rsp_type  rsp_ff;

   assign gain_tag = tag_ff[ST_GAIN];
   assign base     = gain_tag.grid ? wdc_pkg::GRID_LEVEL : '0;

   always_comb begin
      if (gain_tag.nz) begin
         rsp_in.red   = sat_add(base, red_ff);
         rsp_in.green = sat_add(base, green2_ff);
         rsp_in.blue  = sat_add(base, blue_ff);
         rsp_in.alpha = wdc_pkg::FULL_LEVEL;
      end else begin
         rsp_in.red   = base;
         rsp_in.green = base;
         rsp_in.blue  = base;
         rsp_in.alpha = gain_tag.grid ? wdc_pkg::FULL_LEVEL : '0;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = tag_ff[NST-1].vld;
   assign rsp_data   = rsp_ff;

   // ------------------------------------------------------------------------
   // Checks.
   // ------------------------------------------------------------------------
   a_accept_gives_result : assert property (
      @(posedge clock) disable iff (reset) accept |-> ##NST rsp_strobe
   ) else $error("accepted pixel did not produce a result");

   a_result_has_source : assert property (
      @(posedge clock) disable iff (reset) rsp_strobe |-> $past(accept, NST)
   ) else $error("result without a matching accepted pixel");

   a_div_remainder : assert property (
      @(posedge clock) disable iff (reset) tag_ff[ST_QUOT].vld |-> (rem_ff[FB] < lm)
   ) else $error("divider remainder not below the divisor");

   a_clear_pixel : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.alpha == '0)) |->
         ((rsp_data.red == '0) && (rsp_data.green == '0) && (rsp_data.blue == '0))
   ) else $error("transparent pixel carries colour");

   a_no_write_in_flight : assert property (
      @(posedge clock) disable iff (reset) (csr_valid && csr_ready) |=> !tag_ff[0].vld
   ) else $error("pixel accepted together with a register write");

endmodule

@@ rtl/core/wdc_log2.sv @@
// ----------------------------------------------------------------------------
// wdc_log2
// Three-stage fixed-point log2: leading-one position, normalise and take the
// eight bits below the leading one, then look up the fraction.
// ----------------------------------------------------------------------------
module wdc_log2 #(
   parameter int VAL_BITS = wdc_pkg::DENSITY_BITS + 1,
   parameter int LOG_BITS = wdc_pkg::LOG_BITS
) (
   input  logic                clock,
   input  logic [VAL_BITS-1:0] value,
   output logic [LOG_BITS-1:0] result
);

   localparam int POS_BITS = LOG_BITS - wdc_pkg::FRAC_BITS;
   localparam logic [POS_BITS-1:0] TOP_POS = POS_BITS'(VAL_BITS - 1);

   logic [POS_BITS-1:0]          pos_in;
   logic [POS_BITS-1:0]          pos_ff;
   logic [VAL_BITS-1:0]          val_ff;
   logic [VAL_BITS-1:0]          norm;
   logic [POS_BITS-1:0]          pos2_ff;
   logic [wdc_pkg::IDX_BITS-1:0] idx_ff;
   logic [LOG_BITS-1:0]          log_ff;

   always_comb begin
      pos_in = '0;
      for (int i = 0; i < VAL_BITS; i++) begin
         if (value[i]) begin
            pos_in = POS_BITS'(i);
         end
      end
   end

   // Shift the leading one up to the top bit; zeros fill from the right.
   assign norm = val_ff << (TOP_POS - pos_ff);

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      val_ff  <= value;
      pos2_ff <= pos_ff;
      idx_ff  <= norm[VAL_BITS-2 -: wdc_pkg::IDX_BITS];
      log_ff  <= {pos2_ff, wdc_pkg::frac_of(idx_ff)};
   end

   assign result = log_ff;

endmodule
